FILE: rtl/core/nfpe_pkg.sv
// Shared types, flash command codes and helpers for the NOR flash
// program/erase sequencer. No dependencies.
package nfpe_pkg;

  // Configuration defaults
  localparam int DEF_PARTITIONS  = 4;
  localparam int DEF_CHUNK_WORDS = 256;
  localparam int CFG_IDX_W       = 3;
  localparam int MAX_RESULTS     = 3;
  localparam int RES_CNT_W       = 2;

  // Flash command words (Intel command set)
  localparam logic [15:0] FCMD_BUF_PROGRAM = 16'h00E8;
  localparam logic [15:0] FCMD_CONFIRM     = 16'h00D0;
  localparam logic [15:0] FCMD_CLR_STATUS  = 16'h0050;
  localparam logic [15:0] FCMD_READ_ARRAY  = 16'h00FF;
  localparam logic [15:0] FCMD_BLOCK_ERASE = 16'h0020;
  localparam int          STATUS_READY_BIT = 7;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_STATUS = 2'd2,
    CMD_ERASE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_POLL  = 2'd1,
    OP_DONE  = 2'd2
  } bus_op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_PART   = 2'd1,
    ST_BAD_OFFSET = 2'd2
  } status_t;

  // One input beat
  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  partition;
    logic [31:0] offset;
    logic [31:0] byte_count;
    logic [15:0] data_word;
    logic [15:0] status_word;
  } item_t;

  // One result (last is derived at the output)
  typedef struct packed {
    bus_op_t     op;
    logic [31:0] addr;
    logic [15:0] data;
    status_t     code;
    logic [31:0] bytes;
  } res_t;

  // Up to three results of one input beat
  typedef struct packed {
    res_t [MAX_RESULTS-1:0] res;
    logic [RES_CNT_W-1:0]   cnt;
  } bund_t;

  function automatic res_t mk_write(input logic [31:0] addr, input logic [15:0] data);
    res_t r;
    r       = '0;
    r.op    = OP_WRITE;
    r.addr  = addr;
    r.data  = data;
    r.code  = ST_OK;
    return r;
  endfunction

  function automatic res_t mk_poll(input logic [31:0] addr);
    res_t r;
    r      = '0;
    r.op   = OP_POLL;
    r.addr = addr;
    r.code = ST_OK;
    return r;
  endfunction

  function automatic res_t mk_done(input status_t code, input logic [31:0] bytes);
    res_t r;
    r       = '0;
    r.op    = OP_DONE;
    r.code  = code;
    r.bytes = bytes;
    return r;
  endfunction

endpackage

FILE: rtl/core/nfpe_in_if.sv
// Request channel: valid/ready handshake with the request payload.
// No dependencies.
interface nfpe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  partition;
  logic [31:0] offset;
  logic [31:0] byte_count;
  logic [15:0] data_word;
  logic [15:0] status_word;

  modport source (output valid, cmd, partition, offset, byte_count, data_word,
                  status_word, input ready);
  modport sink   (input valid, cmd, partition, offset, byte_count, data_word,
                  status_word, output ready);
endinterface

FILE: rtl/core/nfpe_out_if.sv
// Result channel: valid/ready handshake with bus access / completion payload.
// No dependencies.
interface nfpe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  bus_op;
  logic [31:0] bus_addr;
  logic [15:0] bus_data;
  logic [1:0]  status_code;
  logic [31:0] prog_bytes;
  logic        last;

  modport source (output valid, bus_op, bus_addr, bus_data, status_code,
                  prog_bytes, last, input ready);
  modport sink   (input valid, bus_op, bus_addr, bus_data, status_code,
                  prog_bytes, last, output ready);
endinterface

FILE: rtl/core/nor_flash_program_erase_sequencer.sv
// Buffered program / block erase sequencer for a 16-bit NOR flash. A request
// beat is registered on entry, decoded in one pass against the sequencer
// state, and its up to three bus results are loaded into a result register
// that drains one beat per cycle while the receiver is ready. One request beat
// is accepted every cycle while each produces at most one result and the
// receiver is ready; a beat producing more results holds the input until the
// single result port has taken its last result. Configuration writes take
// effect on the next cycle. Depends on nfpe_pkg, nfpe_in_if, nfpe_out_if and
// nfpe_out_buf.
module nor_flash_program_erase_sequencer
  import nfpe_pkg::*;
#(
  parameter int PARTITIONS  = DEF_PARTITIONS,
  parameter int CHUNK_WORDS = DEF_CHUNK_WORDS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  nfpe_in_if.sink              in_ch,
  nfpe_out_if.source           out_ch
);

  localparam int          CLW      = $clog2(CHUNK_WORDS + 1);
  localparam logic [2:0]  PART_LIM = 3'(PARTITIONS);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETUP,
    PH_FILL,
    PH_CONFIRM,
    PH_ERASE
  } phase_t;

  // Partition table
  logic [31:0] part_base_r [PARTITIONS];
  logic [31:0] part_size_r [PARTITIONS];

  // Input register and sequencer state
  item_t       it_r;
  logic        it_v_r;
  phase_t      phase_r, phase_nxt;
  logic [31:0] cur_addr_r, cur_addr_nxt;
  logic [30:0] words_left_r, words_left_nxt;
  logic [CLW-1:0] chunk_len_r, chunk_len_nxt;
  logic [CLW-1:0] fill_count_r, fill_count_nxt;
  logic [30:0] total_words_r, total_words_nxt;

  logic        fire;
  logic        buf_free;
  bund_t       bund;
  logic        in_fire;

  // Decode helpers
  logic [31:0] sel_base, sel_size, avail, len, sum_addr, next_addr;
  logic        bad_part, off_out, short_len, st_ready;
  logic [30:0] wl_after;
  logic [CLW-1:0] fill_inc;

  function automatic logic [CLW-1:0] chunk_of(input logic [30:0] w);
    chunk_of = (w > 31'(CHUNK_WORDS)) ? CLW'(CHUNK_WORDS) : w[CLW-1:0];
  endfunction

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign fire        = it_v_r && buf_free;
  assign in_ch.ready = !it_v_r || fire;

  // Partition select and write length
  always_comb begin
    sel_base = '0;
    sel_size = '0;
    for (int i = 0; i < PARTITIONS; i++) begin
      if (it_r.partition == 3'(i)) begin
        sel_base = part_base_r[i];
        sel_size = part_size_r[i];
      end
    end
  end

  assign bad_part  = (it_r.partition >= PART_LIM);
  assign off_out   = (it_r.offset >= sel_size);
  assign avail     = sel_size - it_r.offset;
  assign len       = (avail > it_r.byte_count) ? it_r.byte_count : avail;
  assign short_len = (len <= 32'd2);
  assign sum_addr  = sel_base + it_r.offset;
  assign st_ready  = it_r.status_word[STATUS_READY_BIT];
  assign fill_inc  = fill_count_r + CLW'(1);
  assign next_addr = cur_addr_r + 32'({chunk_len_r, 1'b0});
  assign wl_after  = words_left_r - 31'(chunk_len_r);

  // Step decode
  always_comb begin
    phase_nxt       = phase_r;
    cur_addr_nxt    = cur_addr_r;
    words_left_nxt  = words_left_r;
    chunk_len_nxt   = chunk_len_r;
    fill_count_nxt  = fill_count_r;
    total_words_nxt = total_words_r;
    bund            = '0;

    case (phase_r)
      PH_IDLE: begin
        if (it_r.cmd == CMD_WRITE) begin
          bund.cnt = RES_CNT_W'(1);
          if (bad_part) begin
            bund.res[0] = mk_done(ST_BAD_PART, '0);
          end else if (off_out || short_len) begin
            bund.res[0] = mk_done(ST_OK, '0);
          end else begin
            cur_addr_nxt    = sum_addr;
            total_words_nxt = len[31:1];
            words_left_nxt  = len[31:1];
            chunk_len_nxt   = chunk_of(len[31:1]);
            fill_count_nxt  = '0;
            bund.res[0]     = mk_write(sum_addr, FCMD_BUF_PROGRAM);
            bund.res[1]     = mk_poll(sum_addr);
            bund.cnt        = RES_CNT_W'(2);
            phase_nxt       = PH_SETUP;
          end
        end else if (it_r.cmd == CMD_ERASE) begin
          bund.cnt = RES_CNT_W'(1);
          if (bad_part) begin
            bund.res[0] = mk_done(ST_BAD_PART, '0);
          end else if (off_out) begin
            bund.res[0] = mk_done(ST_BAD_OFFSET, '0);
          end else begin
            cur_addr_nxt = sum_addr;
            bund.res[0]  = mk_write(sum_addr, FCMD_BLOCK_ERASE);
            bund.res[1]  = mk_write(sum_addr, FCMD_CONFIRM);
            bund.res[2]  = mk_poll(sum_addr);
            bund.cnt     = RES_CNT_W'(3);
            phase_nxt    = PH_ERASE;
          end
        end
      end
      PH_SETUP: begin
        if (it_r.cmd == CMD_STATUS) begin
          if (!st_ready) begin
            bund.res[0] = mk_write(cur_addr_r, FCMD_BUF_PROGRAM);
            bund.res[1] = mk_poll(cur_addr_r);
            bund.cnt    = RES_CNT_W'(2);
          end else begin
            bund.res[0]    = mk_write(cur_addr_r,
                                      16'(CLW'(chunk_len_r - CLW'(1))));
            bund.cnt       = RES_CNT_W'(1);
            fill_count_nxt = '0;
            phase_nxt      = PH_FILL;
          end
        end
      end
      PH_FILL: begin
        if (it_r.cmd == CMD_DATA) begin
          bund.res[0]    = mk_write(cur_addr_r + 32'({fill_count_r, 1'b0}),
                                    it_r.data_word);
          bund.cnt       = RES_CNT_W'(1);
          fill_count_nxt = fill_inc;
          if (fill_inc >= chunk_len_r) begin
            bund.res[1] = mk_write(cur_addr_r, FCMD_CONFIRM);
            bund.res[2] = mk_poll(cur_addr_r);
            bund.cnt    = RES_CNT_W'(3);
            phase_nxt   = PH_CONFIRM;
          end
        end
      end
      PH_CONFIRM: begin
        if (it_r.cmd == CMD_STATUS) begin
          if (!st_ready) begin
            bund.res[0] = mk_poll(cur_addr_r);
            bund.cnt    = RES_CNT_W'(1);
          end else begin
            bund.res[0]    = mk_write(cur_addr_r, FCMD_CLR_STATUS);
            cur_addr_nxt   = next_addr;
            words_left_nxt = wl_after;
            bund.cnt       = RES_CNT_W'(3);
            if (wl_after != '0) begin
              chunk_len_nxt  = chunk_of(wl_after);
              fill_count_nxt = '0;
              bund.res[1]    = mk_write(next_addr, FCMD_BUF_PROGRAM);
              bund.res[2]    = mk_poll(next_addr);
              phase_nxt      = PH_SETUP;
            end else begin
              bund.res[1] = mk_write(next_addr, FCMD_READ_ARRAY);
              bund.res[2] = mk_done(ST_OK, {total_words_r, 1'b0});
              phase_nxt   = PH_IDLE;
            end
          end
        end
      end
      PH_ERASE: begin
        if (it_r.cmd == CMD_STATUS) begin
          if (!st_ready) begin
            bund.res[0] = mk_poll(cur_addr_r);
            bund.cnt    = RES_CNT_W'(1);
          end else begin
            bund.res[0] = mk_write(cur_addr_r, FCMD_CLR_STATUS);
            bund.res[1] = mk_write(cur_addr_r, FCMD_READ_ARRAY);
            bund.res[2] = mk_done(ST_OK, '0);
            bund.cnt    = RES_CNT_W'(3);
            phase_nxt   = PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // State, input register and partition table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_v_r        <= 1'b0;
      phase_r       <= PH_IDLE;
      cur_addr_r    <= '0;
      words_left_r  <= '0;
      chunk_len_r   <= '0;
      fill_count_r  <= '0;
      total_words_r <= '0;
      for (int i = 0; i < PARTITIONS; i++) begin
        part_base_r[i] <= '0;
        part_size_r[i] <= '0;
      end
    end else begin
      if (in_fire) begin
        it_v_r <= 1'b1;
      end else if (fire) begin
        it_v_r <= 1'b0;
      end
      if (fire) begin
        phase_r       <= phase_nxt;
        cur_addr_r    <= cur_addr_nxt;
        words_left_r  <= words_left_nxt;
        chunk_len_r   <= chunk_len_nxt;
        fill_count_r  <= fill_count_nxt;
        total_words_r <= total_words_nxt;
      end
      for (int i = 0; i < PARTITIONS; i++) begin
        if (cfg_we && cfg_index == CFG_IDX_W'(2 * i)) begin
          part_base_r[i] <= cfg_wdata;
        end
        if (cfg_we && cfg_index == CFG_IDX_W'(2 * i + 1)) begin
          part_size_r[i] <= cfg_wdata;
        end
      end
    end
  end

  // Request payload register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_r.cmd         <= cmd_t'(in_ch.cmd);
      it_r.partition   <= in_ch.partition;
      it_r.offset      <= in_ch.offset;
      it_r.byte_count  <= in_ch.byte_count;
      it_r.data_word   <= in_ch.data_word;
      it_r.status_word <= in_ch.status_word;
    end
  end

  nfpe_out_buf u_out_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (fire && (bund.cnt != '0)),
    .bund   (bund),
    .free   (buf_free),
    .out_ch (out_ch)
  );

  // Checks
  a_chunk_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SETUP || phase_r == PH_FILL || phase_r == PH_CONFIRM)
      |-> (chunk_len_r != '0 && chunk_len_r <= CLW'(CHUNK_WORDS)))
    else $error("chunk length out of range");

  a_fill_below_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FILL) |-> (fill_count_r < chunk_len_r))
    else $error("buffer fill count overran chunk");

  a_words_cover_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SETUP || phase_r == PH_FILL || phase_r == PH_CONFIRM)
      |-> (words_left_r >= 31'(chunk_len_r)))
    else $error("chunk longer than remaining words");

endmodule

FILE: rtl/core/nfpe_out_buf.sv
// Result register: holds the results of one request beat and hands them
// out one beat at a time. Depends on nfpe_pkg and nfpe_out_if.
module nfpe_out_buf
  import nfpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  bund_t             bund,
  output logic              free,
  nfpe_out_if.source        out_ch
);

  bund_t                bund_r;
  logic                 valid_r;
  logic [RES_CNT_W-1:0] idx_r;
  logic                 is_last;
  logic                 out_fire;
  res_t                 cur;

  // Current beat
  assign cur      = bund_r.res[idx_r];
  assign is_last  = (idx_r == RES_CNT_W'(bund_r.cnt - 1'b1));
  assign out_fire = valid_r && out_ch.ready;
  assign free     = !valid_r || (out_fire && is_last);

  assign out_ch.valid       = valid_r;
  assign out_ch.bus_op      = cur.op;
  assign out_ch.bus_addr    = cur.addr;
  assign out_ch.bus_data    = cur.data;
  assign out_ch.status_code = cur.code;
  assign out_ch.prog_bytes  = cur.bytes;
  assign out_ch.last        = is_last;

  // Load / advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (out_fire) begin
      if (is_last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bund_r <= bund;
    end
  end

  // Checks
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free) else $error("result bundle overwritten before drained");

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (bund.cnt != '0)) else $error("empty bundle loaded");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (idx_r < bund_r.cnt)) else $error("result index past count");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !is_last && !load) |=> (valid_r && idx_r == $past(idx_r) + 1'b1))
    else $error("result bundle did not advance");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the NOR flash program/erase sequencer: directed table, then random
// program/erase sequences under three partition maps, checked against an in-bench model.
// Depends on nfpe_pkg, nfpe_in_if, nfpe_out_if and the sequencer RTL.
module tb_top;
  import nfpe_pkg::*;

  localparam int NPART           = DEF_PARTITIONS;
  localparam int CHUNK           = DEF_CHUNK_WORDS;
  localparam int SETTLE_CYCLES   = 8;    // pipeline drain before a register write
  localparam int HOLD_OFF_CYCLES = 300;  // long receiver stall to back up the block
  localparam int LIVE_PER_MAP    = 50;   // request beats with results per partition map

  typedef enum logic [2:0] {
    REG_P0_BASE = 3'd0,
    REG_P0_SIZE = 3'd1,
    REG_P1_BASE = 3'd2,
    REG_P1_SIZE = 3'd3,
    REG_P2_BASE = 3'd4,
    REG_P2_SIZE = 3'd5,
    REG_P3_BASE = 3'd6,
    REG_P3_SIZE = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_SETUP, SEQ_FILL, SEQ_CONFIRM, SEQ_ERASE
  } seq_phase_t;

  typedef enum int {PACE_OPEN, PACE_COIN, PACE_MOSTLY, PACE_PATTERN} pace_t;
  typedef enum bit {ROW_BEAT, ROW_CFG} row_kind_t;

  // One expected beat on the result channel
  typedef struct packed {
    bus_op_t     op;
    logic [31:0] addr;
    logic [15:0] data;
    status_t     code;
    logic [31:0] bytes;
    logic        last;
  } flash_beat_t;

  // Directed table row: a request beat or a register write
  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    reg_idx;
    logic [31:0] value;
    cmd_t        cmd;
    logic [2:0]  partition;
    logic [31:0] offset;
    logic [31:0] byte_count;
    logic [15:0] data_word;
    logic [15:0] status_word;
    bit          typed;      // expectation is a single completion with exp_code
    status_t     exp_code;
  } dir_row_t;

  localparam int N_DIR = 33;

  // kind, reg, value, cmd, part, offset, count, data, status, typed, code
  dir_row_t dir_rows [N_DIR] = '{
    // all partitions empty after reset
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_WRITE, 3'd0, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'h0, 1, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_ERASE, 3'd0, 32'h0, 32'h0, 16'h0, 16'h0, 1, ST_BAD_OFFSET},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_WRITE, 3'd7, 32'h0, 32'h10, 16'h0, 16'h0, 1, ST_BAD_PART},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_ERASE, 3'd4, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'h0, 1,
      ST_BAD_PART},
    // status while idle is dropped
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_STATUS, 3'd0, 32'h0, 32'h0, 16'h0, 16'hFFFF, 0, ST_OK},
    // partition map with extremes
    '{ROW_CFG, REG_P0_BASE, 32'hFFFF_FFFC, CMD_WRITE, 3'd0, 0, 0, 0, 0, 0, ST_OK},
    '{ROW_CFG, REG_P0_SIZE, 32'h0000_0100, CMD_WRITE, 3'd0, 0, 0, 0, 0, 0, ST_OK},
    '{ROW_CFG, REG_P1_BASE, 32'h0000_2000, CMD_WRITE, 3'd0, 0, 0, 0, 0, 0, ST_OK},
    '{ROW_CFG, REG_P1_SIZE, 32'hFFFF_FFFF, CMD_WRITE, 3'd0, 0, 0, 0, 0, 0, ST_OK},
    '{ROW_CFG, REG_P2_BASE, 32'h0000_0000, CMD_WRITE, 3'd0, 0, 0, 0, 0, 0, ST_OK},
    '{ROW_CFG, REG_P2_SIZE, 32'h0000_0003, CMD_WRITE, 3'd0, 0, 0, 0, 0, 0, ST_OK},
    '{ROW_CFG, REG_P3_BASE, 32'h8000_0000, CMD_WRITE, 3'd0, 0, 0, 0, 0, 0, ST_OK},
    '{ROW_CFG, REG_P3_SIZE, 32'h0000_0000, CMD_WRITE, 3'd0, 0, 0, 0, 0, 0, ST_OK},
    // clipped to two bytes, one byte, and offset past the end
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_WRITE, 3'd2, 32'h1, 32'hFFFF_FFFF, 16'h0, 16'h0, 1, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_WRITE, 3'd1, 32'hFFFF_FFFE, 32'h5, 16'h0, 16'h0, 1, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_ERASE, 3'd3, 32'h0, 32'h0, 16'h0, 16'h0, 1, ST_BAD_OFFSET},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_WRITE, 3'd0, 32'h100, 32'h40, 16'h0, 16'h0, 1, ST_OK},
    // three-word program, address wraps past 2^32
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_WRITE, 3'd0, 32'hFA, 32'hFFFF_FFFF, 16'h0, 16'h0, 0, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_STATUS, 3'd0, 32'h0, 32'h0, 16'h0, 16'hFF7F, 0, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_STATUS, 3'd0, 32'h0, 32'h0, 16'h0, 16'h0080, 0, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_DATA, 3'd0, 32'h0, 32'h0, 16'h0000, 16'h0, 0, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_DATA, 3'd0, 32'h0, 32'h0, 16'hFFFF, 16'h0, 0, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_ERASE, 3'd0, 32'h0, 32'h0, 16'h0, 16'h0, 0, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_DATA, 3'd0, 32'h0, 32'h0, 16'hA5A5, 16'h0, 0, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_STATUS, 3'd0, 32'h0, 32'h0, 16'h0, 16'h0000, 0, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_STATUS, 3'd0, 32'h0, 32'h0, 16'h0, 16'hFFFF, 0, ST_OK},
    // erase at the top of a full-range partition, request while busy is dropped
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_ERASE, 3'd1, 32'hFFFF_FFFE, 32'h0, 16'h0, 16'h0, 0, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_WRITE, 3'd1, 32'h0, 32'h40, 16'h0, 16'h0, 0, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_STATUS, 3'd0, 32'h0, 32'h0, 16'h0, 16'h0080, 0, ST_OK},
    // three bytes move a single word
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_WRITE, 3'd2, 32'h0, 32'h3, 16'h0, 16'h0, 0, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_STATUS, 3'd0, 32'h0, 32'h0, 16'h0, 16'h0080, 0, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_DATA, 3'd0, 32'h0, 32'h0, 16'h5A5A, 16'h0, 0, ST_OK},
    '{ROW_BEAT, REG_P0_BASE, 0, CMD_STATUS, 3'd0, 32'h0, 32'h0, 16'h0, 16'h0080, 0, ST_OK}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  nfpe_in_if  in_ch ();
  nfpe_out_if out_ch ();

  nor_flash_program_erase_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state: partition map and sequencer registers
  logic [31:0] part_base [NPART];
  logic [31:0] part_size [NPART];
  seq_phase_t  seq_phase;
  logic [31:0] blk_addr;
  logic [30:0] words_left;
  logic [8:0]  chunk_words;
  logic [8:0]  fill_words;
  logic [30:0] total_words;

  flash_beat_t step_beats[$];     // results of the beat being accepted
  flash_beat_t bus_beats_due[$];  // results not yet seen on the output

  int fail_count  = 0;
  int beats_sent  = 0;
  int beats_live  = 0;
  int beats_seen  = 0;
  int done_seen   = 0;
  int error_seen  = 0;
  int cfg_writes  = 0;
  int burst_left  = 0;
  bit squeeze_go  = 1'b0;

  function automatic void add_beat(bus_op_t op, logic [31:0] addr, logic [15:0] data,
                                   status_t code, logic [31:0] bytes);
    flash_beat_t b;
    b = '{op: op, addr: addr, data: data, code: code, bytes: bytes, last: 1'b0};
    step_beats.push_back(b);
  endfunction

  function automatic void add_write(logic [31:0] addr, logic [15:0] data);
    add_beat(OP_WRITE, addr, data, ST_OK, 32'd0);
  endfunction

  function automatic void add_poll(logic [31:0] addr);
    add_beat(OP_POLL, addr, 16'd0, ST_OK, 32'd0);
  endfunction

  function automatic void add_done(status_t code, logic [31:0] bytes);
    add_beat(OP_DONE, 32'd0, 16'd0, code, bytes);
  endfunction

  // Program length after clipping to the partition end and the count; offset is in range
  function automatic logic [31:0] clip_len(logic [2:0] part, logic [31:0] off,
                                           logic [31:0] cnt);
    logic [31:0] len;
    len = part_size[part] - off;
    return (len > cnt) ? cnt : len;
  endfunction

  function automatic void begin_chunk();
    chunk_words = (words_left > CHUNK) ? 9'(CHUNK) : words_left[8:0];
    fill_words  = '0;
    add_write(blk_addr, FCMD_BUF_PROGRAM);
    add_poll(blk_addr);
    seq_phase = SEQ_SETUP;
  endfunction

  // Sequencer model: one accepted request beat -> step_beats
  function automatic void sequencer_step(item_t it);
    logic        rdy;
    logic [31:0] len;
    rdy = it.status_word[STATUS_READY_BIT];
    step_beats.delete();
    case (seq_phase)
      SEQ_IDLE: begin
        if (it.cmd == CMD_WRITE || it.cmd == CMD_ERASE) begin
          if (it.partition >= NPART) begin
            add_done(ST_BAD_PART, 32'd0);
          end else if (it.offset >= part_size[it.partition]) begin
            add_done((it.cmd == CMD_WRITE) ? ST_OK : ST_BAD_OFFSET, 32'd0);
          end else if (it.cmd == CMD_ERASE) begin
            blk_addr = part_base[it.partition] + it.offset;
            add_write(blk_addr, FCMD_BLOCK_ERASE);
            add_write(blk_addr, FCMD_CONFIRM);
            add_poll(blk_addr);
            seq_phase = SEQ_ERASE;
          end else begin
            len = clip_len(it.partition, it.offset, it.byte_count);
            if (len <= 32'd2) begin
              add_done(ST_OK, 32'd0);
            end else begin
              blk_addr    = part_base[it.partition] + it.offset;
              total_words = len[31:1];
              words_left  = total_words;
              begin_chunk();
            end
          end
        end
      end
      SEQ_SETUP: if (it.cmd == CMD_STATUS) begin
        if (!rdy) begin
          add_write(blk_addr, FCMD_BUF_PROGRAM);
          add_poll(blk_addr);
        end else begin
          add_write(blk_addr, 16'(chunk_words - 1));
          fill_words = '0;
          seq_phase  = SEQ_FILL;
        end
      end
      SEQ_FILL: if (it.cmd == CMD_DATA) begin
        add_write(blk_addr + 32'(fill_words) * 2, it.data_word);
        fill_words = fill_words + 9'd1;
        if (fill_words >= chunk_words) begin
          add_write(blk_addr, FCMD_CONFIRM);
          add_poll(blk_addr);
          seq_phase = SEQ_CONFIRM;
        end
      end
      SEQ_CONFIRM: if (it.cmd == CMD_STATUS) begin
        if (!rdy) begin
          add_poll(blk_addr);
        end else begin
          add_write(blk_addr, FCMD_CLR_STATUS);
          blk_addr   = blk_addr + 32'(chunk_words) * 2;
          words_left = words_left - 31'(chunk_words);
          if (words_left != '0) begin
            begin_chunk();
          end else begin
            add_write(blk_addr, FCMD_READ_ARRAY);
            add_done(ST_OK, {total_words, 1'b0});
            seq_phase = SEQ_IDLE;
          end
        end
      end
      SEQ_ERASE: if (it.cmd == CMD_STATUS) begin
        if (!rdy) begin
          add_poll(blk_addr);
        end else begin
          add_write(blk_addr, FCMD_CLR_STATUS);
          add_write(blk_addr, FCMD_READ_ARRAY);
          add_done(ST_OK, 32'd0);
          seq_phase = SEQ_IDLE;
        end
      end
      default: ;
    endcase
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
  endfunction

  // Request beat with every field but the command random
  function automatic item_t rand_item(cmd_t c);
    item_t r;
    r.cmd         = c;
    r.partition   = 3'($urandom_range(0, 7));
    r.offset      = $urandom;
    r.byte_count  = $urandom;
    r.data_word   = 16'($urandom);
    r.status_word = 16'($urandom);
    return r;
  endfunction

  function automatic logic [31:0] pick_offset(logic [31:0] span);
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return (span > 8) ? span - $urandom_range(1, 8) : 32'($urandom_range(0, 8));
      2:       return span;
      default: return 32'($urandom_range(0, 63));
    endcase
  endfunction

  // Sender: bursts of back-to-back beats with random gaps; model runs at acceptance
  task automatic send_beat(item_t it, bit typed = 1'b0, status_t code = ST_OK);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.cmd         <= it.cmd;
    in_ch.partition   <= it.partition;
    in_ch.offset      <= it.offset;
    in_ch.byte_count  <= it.byte_count;
    in_ch.data_word   <= it.data_word;
    in_ch.status_word <= it.status_word;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sequencer_step(it);
    if (typed) begin
      step_beats.delete();
      add_done(code, 32'd0);
      step_beats[0].last = 1'b1;
    end
    beats_sent++;
    if (step_beats.size() > 0) beats_live++;
    foreach (step_beats[i]) bus_beats_due.push_back(step_beats[i]);
  endtask

  // Block quiet: input parked, all results out, pipeline drained
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (bus_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx[0]) part_size[idx >> 1] = val;
    else        part_base[idx >> 1] = val;
    cfg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_map(int sel);
    logic [31:0] vals [8];
    for (int i = 0; i < 8; i++) vals[i] = $urandom;
    case (sel)
      0: begin
        vals[REG_P0_BASE] = 32'h0;
        vals[REG_P0_SIZE] = 32'h40;
        vals[REG_P1_BASE] = 32'hFFFF_FFF0;
        vals[REG_P1_SIZE] = 32'h600;
        vals[REG_P2_SIZE] = 32'hFFFF_FFFF;
        vals[REG_P3_BASE] = 32'hFFFF_FFFF;
        vals[REG_P3_SIZE] = 32'h20;
      end
      1: begin
        vals[REG_P0_SIZE] = 32'h0;
        vals[REG_P1_SIZE] = $urandom_range(1, 'h800);
        vals[REG_P2_SIZE] = $urandom_range(1, 'h800);
        vals[REG_P3_SIZE] = $urandom_range(1, 'h800);
      end
      default: vals[REG_P0_BASE] = 32'hFFFF_FFFF;
    endcase
    wait_idle();
    for (int i = 0; i < 8; i++) cfg_write(cfg_reg_t'(i), vals[i]);
  endtask

  // One random request, followed through to idle with noise mixed in, or stray beats alone
  task automatic run_random_sequence();
    item_t       it;
    logic [31:0] span;
    logic [31:0] want;
    int          pick;
    pick = $urandom_range(0, 19);
    if (pick >= 17) begin
      // stray data and status beats while idle
      repeat ($urandom_range(1, 3))
        send_beat(rand_item(($urandom_range(0, 1) != 0) ? CMD_DATA : CMD_STATUS));
      return;
    end
    it = rand_item((pick < 12) ? CMD_WRITE : CMD_ERASE);
    it.partition = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(NPART, 7))
                                               : 3'($urandom_range(0, NPART - 1));
    span      = (it.partition < NPART) ? part_size[it.partition] : 32'd0;
    it.offset = pick_offset(span);
    if (it.cmd == CMD_WRITE) begin
      want = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 64) : $urandom_range(0, 24);
      case ($urandom_range(0, 4))
        0:       it.byte_count = 32'hFFFF_FFFF;
        1:       ;
        default: it.byte_count = want;
      endcase
      // keep programs short enough to finish in reasonable time
      if (it.partition < NPART && it.offset < part_size[it.partition] &&
          clip_len(it.partition, it.offset, it.byte_count) > 32'd64)
        it.byte_count = want;
    end
    send_beat(it);
    while (seq_phase != SEQ_IDLE) begin
      if ($urandom_range(0, 9) == 0) begin
        // beat of the wrong kind for this phase
        it = rand_item(cmd_t'($urandom_range(0, 3)));
        if (seq_phase == SEQ_FILL && it.cmd == CMD_DATA) it.cmd = CMD_STATUS;
        if (seq_phase != SEQ_FILL && it.cmd == CMD_STATUS) it.cmd = CMD_DATA;
      end else if (seq_phase == SEQ_FILL) begin
        it = rand_item(CMD_DATA);
      end else begin
        it = rand_item(CMD_STATUS);
        it.status_word[STATUS_READY_BIT] = ($urandom_range(0, 9) < 7);
      end
      send_beat(it);
    end
  endtask

  // Stimulus: reset, directed table, random sequences over three partition maps
  initial begin : stimulus
    item_t it;
    bit    in_cfg;
    in_cfg            = 1'b0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_P0_BASE;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_WRITE;
    in_ch.partition   <= '0;
    in_ch.offset      <= '0;
    in_ch.byte_count  <= '0;
    in_ch.data_word   <= '0;
    in_ch.status_word <= '0;
    for (int p = 0; p < NPART; p++) begin
      part_base[p] = '0;
      part_size[p] = '0;
    end
    seq_phase   = SEQ_IDLE;
    blk_addr    = '0;
    words_left  = '0;
    chunk_words = '0;
    fill_words  = '0;
    total_words = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        if (!in_cfg) wait_idle();
        in_cfg = 1'b1;
        cfg_write(dir_rows[r].reg_idx, dir_rows[r].value);
      end else begin
        in_cfg         = 1'b0;
        it.cmd         = dir_rows[r].cmd;
        it.partition   = dir_rows[r].partition;
        it.offset      = dir_rows[r].offset;
        it.byte_count  = dir_rows[r].byte_count;
        it.data_word   = dir_rows[r].data_word;
        it.status_word = dir_rows[r].status_word;
        send_beat(it, dir_rows[r].typed, dir_rows[r].exp_code);
      end
    end

    for (int m = 0; m < 3; m++) begin
      int target;
      apply_map(m);
      // hold-off starts once requests are flowing again
      squeeze_go = 1'b1;
      target = beats_live + LIVE_PER_MAP;
      while (beats_live < target) run_random_sequence();
    end

    in_ch.valid <= 1'b0;
    while (bus_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d request beats (%0d producing results), %0d register writes",
             beats_sent, beats_live, cfg_writes);
    $display("checked %0d result beats, %0d completions (%0d with error codes)",
             beats_seen, done_seen, error_seen);
    if (fail_count == 0)
      $display("nor_flash_program_erase_sequencer regression: pass");
    else
      $display("nor_flash_program_erase_sequencer regression: fail");
    $finish;
  end

  // Receiver: random pacing modes, plus one long hold-off once random traffic starts
  initial begin : result_pacing
    pace_t       mode;
    int          span;
    logic [15:0] pat;
    bit          squeezed;
    squeezed = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      if (squeeze_go && !squeezed) begin
        squeezed = 1'b1;
        @(posedge clk);
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode = pace_t'($urandom_range(0, 3));
      span = $urandom_range(16, 96);
      pat  = 16'($urandom);
      for (int c = 0; c < span; c++) begin
        if (squeeze_go && !squeezed) break;
        @(posedge clk);
        case (mode)
          PACE_OPEN:   out_ch.ready <= 1'b1;
          PACE_COIN:   out_ch.ready <= ($urandom_range(0, 1) != 0);
          PACE_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default:     out_ch.ready <= pat[c % 16];
        endcase
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // Result checker: every accepted beat against the oldest expectation
  initial begin : result_check
    flash_beat_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        beats_seen++;
        if (bus_beats_due.size() == 0) begin
          $error("result beat with nothing expected: op %0d addr 0x%0h data 0x%0h",
                 out_ch.bus_op, out_ch.bus_addr, out_ch.bus_data);
          fail_count++;
        end else begin
          want = bus_beats_due.pop_front();
          check_field("bus_op", want.op, out_ch.bus_op);
          check_field("bus_addr", want.addr, out_ch.bus_addr);
          check_field("bus_data", want.data, out_ch.bus_data);
          check_field("status_code", want.code, out_ch.status_code);
          check_field("prog_bytes", want.bytes, out_ch.prog_bytes);
          check_field("last", want.last, out_ch.last);
          if (want.op == OP_DONE) begin
            done_seen++;
            if (want.code != ST_OK) error_seen++;
          end
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("nor_flash_program_erase_sequencer regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/nfpe_pkg.sv
rtl/core/nfpe_in_if.sv
rtl/core/nfpe_out_if.sv
rtl/core/nfpe_out_buf.sv
rtl/core/nor_flash_program_erase_sequencer.sv
test/tb_top.sv
